/* src/mhpq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_pkg
// shared widths, codes and defaults of the min-heap priority queue
// ----------------------------------------------------------------------------
package mhpq_pkg;

   localparam int DEPTH_DEF    = 16;
   localparam int KEY_BITS_DEF = 32;
   localparam int TAG_BITS_DEF = 16;

   localparam int CFG_BITS    = 5;
   localparam int STATUS_BITS = 2;

   localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   localparam logic [CFG_BITS-1:0] LIMIT_RESET = 5'd16;
   // byte address of the capacity limit register
   localparam logic [1:0]          REG_LIMIT   = 2'd0;

endpackage
`default_nettype wire

/* src/mhpq_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_req_if / mhpq_rsp_if
// valid/ready channels of the queue
// ----------------------------------------------------------------------------
interface mhpq_req_if #(
   parameter int KEY_BITS = 32,
   parameter int TAG_BITS = 16
) ();
   logic                req_valid;
   logic                req_ready;
   logic                req_type;
   logic [KEY_BITS-1:0] entry_key;
   logic [TAG_BITS-1:0] entry_tag;
   modport source (output req_valid, req_type, entry_key, entry_tag, input req_ready);
   modport sink   (input req_valid, req_type, entry_key, entry_tag, output req_ready);
endinterface

interface mhpq_rsp_if #(
   parameter int KEY_BITS = 32,
   parameter int TAG_BITS = 16,
   parameter int CNT_BITS = 5
) ();
   logic                rsp_valid;
   logic                rsp_ready;
   logic [1:0]          status;
   logic [KEY_BITS-1:0] out_key;
   logic [TAG_BITS-1:0] out_tag;
   logic [CNT_BITS-1:0] entry_count;
   logic [KEY_BITS-1:0] head_key;
   logic [TAG_BITS-1:0] head_tag;
   modport source (output rsp_valid, status, out_key, out_tag, entry_count, head_key,
                   head_tag, input rsp_ready);
   modport sink   (input rsp_valid, status, out_key, out_tag, entry_count, head_key,
                   head_tag, output rsp_ready);
endinterface
`default_nettype wire

/* src/mhpq_csr.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_csr
// apb register file: capacity limit
// ----------------------------------------------------------------------------
module mhpq_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [1:0]                     csr_paddr,
   input  wire logic [31:0]                    csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready,
   output logic [mhpq_pkg::CFG_BITS-1:0]       limit
);
   import mhpq_pkg::*;

   logic [CFG_BITS-1:0] limit_ff, limit_in;
   logic                sel_limit;

   assign sel_limit  = (csr_paddr == REG_LIMIT);
   assign csr_pready = 1'b1;
   assign limit      = limit_ff;

   always_comb begin
      limit_in = limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && sel_limit) begin
         limit_in = csr_pwdata[CFG_BITS-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (sel_limit) begin
         csr_prdata = {{(32-CFG_BITS){1'b0}}, limit_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end
endmodule
`default_nettype wire

/* src/mhpq_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_core
// heap sequencer around one synchronous memory, sift up / sift down
// ----------------------------------------------------------------------------
module mhpq_core #(
   parameter int DEPTH    = mhpq_pkg::DEPTH_DEF,
   parameter int KEY_BITS = mhpq_pkg::KEY_BITS_DEF,
   parameter int TAG_BITS = mhpq_pkg::TAG_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [mhpq_pkg::CFG_BITS-1:0] limit,
   mhpq_req_if.sink                           req,
   mhpq_rsp_if.source                         rsp
);
   import mhpq_pkg::*;

   localparam int CB = $clog2(DEPTH + 1);  // count bits
   localparam int AB = $clog2(DEPTH);      // address bits (zero-based)
   localparam int EB = KEY_BITS + TAG_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_UP_RD, S_UP_CMP, S_DQ_RD, S_DQ_ROOT, S_DN_RD, S_DN_CMP, S_HEAD_RD,
      S_HEAD, S_OUT
   } state_type;

   // memory: one write and two registered reads a cycle
   logic [EB-1:0] mem [DEPTH];
   logic          we;
   logic [AB-1:0] wa, ra0, ra1;
   logic [EB-1:0] wd, rd0_ff, rd1_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd0_ff <= mem[ra0];
      rd1_ff <= mem[ra1];
   end

   state_type      state_ff, state_in;
   logic [CB-1:0]  cnt_ff, cnt_in;
   logic [CB-1:0]  pos_ff, pos_in;   // one-based position of the moving entry
   logic [CB:0]    ch_ff, ch_in;     // left child, one-based
   logic [EB-1:0]  cur_ff, cur_in;   // moving entry
   logic [1:0]     st_ff, st_in;
   logic [EB-1:0]  out_ff, out_in;
   logic [EB-1:0]  head_ff, head_in;
   logic           vld_ff, vld_in;
   logic [CB-1:0]  lim;

   assign lim = (int'(limit) > DEPTH) ? CB'(DEPTH) : CB'(limit);

   function automatic logic [AB-1:0] adr(input logic [CB:0] p);
      logic [CB:0] q;
      q = p - 1'b1;
      return q[AB-1:0];
   endfunction

   function automatic logic [KEY_BITS-1:0] k(input logic [EB-1:0] e);
      return e[EB-1:TAG_BITS];
   endfunction

   // right child address, wraps harmlessly when out of range
   function automatic logic [AB-1:0] ch_r_ok_next(input logic [CB-1:0] p);
      logic [CB+1:0] q;
      q = {1'b0, p, 1'b0};
      return q[AB-1:0];
   endfunction

   logic          ch_r_ok, pick_r;
   logic [EB-1:0] child;
   logic [CB:0]   cpos;

   always_comb begin
      ch_r_ok = (ch_ff + 1'b1) <= {1'b0, cnt_ff};
      pick_r  = ch_r_ok && (k(rd1_ff) < k(rd0_ff));
      child   = pick_r ? rd1_ff : rd0_ff;
      cpos    = pick_r ? ch_ff + 1'b1 : ch_ff;
   end

   assign req.req_ready = (state_ff == S_IDLE);
   assign rsp.rsp_valid = vld_ff;
   assign rsp.status    = st_ff;
   assign rsp.out_key   = out_ff[EB-1:TAG_BITS];
   assign rsp.out_tag   = out_ff[TAG_BITS-1:0];
   assign rsp.entry_count = cnt_ff;
   assign rsp.head_key  = head_ff[EB-1:TAG_BITS];
   assign rsp.head_tag  = head_ff[TAG_BITS-1:0];

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff; pos_in = pos_ff; ch_in = ch_ff; cur_in = cur_ff;
      st_in = st_ff; out_in = out_ff; head_in = head_ff; vld_in = vld_ff;
      we = 1'b0; wa = '0; wd = cur_ff;
      ra0 = adr({1'b0, pos_ff} >> 1); ra1 = '0;
      case (state_ff)
         S_IDLE: begin
            if (req.req_valid) begin
               st_in = ST_DONE; out_in = '0;
               if (req.req_type == OP_ENQ) begin
                  if (cnt_ff < lim) begin
                     cur_in = {req.entry_key, req.entry_tag};
                     pos_in = cnt_ff + 1'b1;
                     cnt_in = cnt_ff + 1'b1;
                     state_in = S_UP_RD;
                  end else begin
                     st_in = ST_FULL;
                     state_in = S_HEAD_RD;
                  end
               end else if (cnt_ff == '0) begin
                  st_in = ST_EMPTY;
                  state_in = S_HEAD_RD;
               end else begin
                  state_in = S_DQ_RD;
               end
            end
         end
         S_UP_RD: begin
            if (pos_ff == 1) begin
               we = 1'b1; wa = '0; state_in = S_HEAD_RD;
            end else begin
               ra0 = adr({1'b0, pos_ff} >> 1);
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            we = 1'b1; wa = adr({1'b0, pos_ff});
            if (k(cur_ff) < k(rd0_ff)) begin
               wd = rd0_ff;
               pos_in = pos_ff >> 1;
               state_in = S_UP_RD;
            end else begin
               state_in = S_HEAD_RD;
            end
         end
         S_DQ_RD: begin
            ra0 = '0; ra1 = adr({1'b0, cnt_ff});
            state_in = S_DQ_ROOT;
         end
         S_DQ_ROOT: begin
            out_in = rd0_ff; cur_in = rd1_ff;
            cnt_in = cnt_ff - 1'b1;
            pos_in = CB'(1);
            state_in = S_DN_RD;
         end
         S_DN_RD: begin
            ch_in = {1'b0, pos_ff} << 1;
            if (({1'b0, pos_ff} << 1) > {1'b0, cnt_ff}) begin
               we = (cnt_ff != '0); wa = adr({1'b0, pos_ff});
               state_in = S_HEAD_RD;
            end else begin
               ra0 = adr({1'b0, pos_ff} << 1);
               ra1 = ch_r_ok_next(pos_ff);
               state_in = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            we = 1'b1; wa = adr({1'b0, pos_ff});
            if (k(child) < k(cur_ff)) begin
               wd = child;
               pos_in = cpos[CB-1:0];
               state_in = S_DN_RD;
            end else begin
               state_in = S_HEAD_RD;
            end
         end
         S_HEAD_RD: begin
            ra0 = '0;
            state_in = S_HEAD;
         end
         S_HEAD: begin
            head_in = (cnt_ff == '0) ? '0 : rd0_ff;
            vld_in = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp.rsp_ready) begin
               vld_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= '0; vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; vld_ff <= vld_in;
      end
      pos_ff <= pos_in; ch_ff <= ch_in; cur_ff <= cur_in;
      st_ff <= st_in; out_ff <= out_in; head_ff <= head_in;
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CB'(DEPTH)) else $error("count above depth");
   a_full_st: assert property (@(posedge clock) disable iff (reset)
      vld_ff && st_ff == ST_FULL |-> cnt_ff >= lim) else $error("drop while room");
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      vld_ff && cnt_ff == '0 |-> head_ff == '0) else $error("head of empty queue");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff && !rsp.rsp_ready |=> vld_ff && $stable(cnt_ff)) else $error("word lost");
endmodule
`default_nettype wire

/* src/min_heap_priority_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// min_heap_priority_queue
// binary min-heap priority queue on one synchronous memory
// ----------------------------------------------------------------------------
//  channel   ports   dir  word
//  request   req_*   in   req_type, entry_key, entry_tag
//  response  rsp_*   out  status, out_key, out_tag, entry_count, head_*
//  config    csr_*   in   apb, capacity_limit at 0x0
//
//  a full or empty request goes straight to the head read and the response; an
//  enqueue climbs one heap level per memory read and compare, and a dequeue reads the
//  root and the last entry, then descends one level per memory read and compare. one
//  word in flight; the response register holds under stall and the next request
//  waits until taken. synchronous reset empties the queue and sets the limit to 16.
module min_heap_priority_queue #(
   parameter int DEPTH    = mhpq_pkg::DEPTH_DEF,
   parameter int KEY_BITS = mhpq_pkg::KEY_BITS_DEF,
   parameter int TAG_BITS = mhpq_pkg::TAG_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   mhpq_req_if.sink         req,
   mhpq_rsp_if.source       rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import mhpq_pkg::*;

   logic [CFG_BITS-1:0] limit;

   mhpq_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready, .limit
   );

   mhpq_core #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS), .TAG_BITS(TAG_BITS)) u_core (
      .clock, .reset, .limit, .req, .rsp
   );
endmodule
`default_nettype wire

/* dv/min_heap_priority_queue_tb.sv */
// ----------------------------------------------------------------------------
// min_heap_priority_queue_tb
// random and directed enqueue/dequeue traffic with a heap predictor and
// in-order comparison of every response word, across several queue limits
// ----------------------------------------------------------------------------
module min_heap_priority_queue_tb;
   import mhpq_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] out_key;
      logic [15:0] out_tag;
      logic [4:0]  entry_count;
      logic [31:0] head_key;
      logic [15:0] head_tag;
   } rsp_word_type;

   class heap_scoreboard;
      logic [31:0]  keys [1:16];
      logic [15:0]  tags [1:16];
      int           held;
      int           limit;
      rsp_word_type pending [$];
      int           errors;

      function void clear();
         held = 0;
         limit = 16;
         errors = 0;
         pending.delete();
      endfunction

      function void swap_slots(int a, int b);
         logic [31:0] k;
         logic [15:0] t;
         k = keys[a]; keys[a] = keys[b]; keys[b] = k;
         t = tags[a]; tags[a] = tags[b]; tags[b] = t;
      endfunction

      function void note_request(logic op, logic [31:0] key, logic [15:0] tag);
         rsp_word_type w;
         int pos, c, lim;
         w = '0;
         w.status = ST_DONE;
         lim = (limit > 16) ? 16 : limit;
         if (op == OP_ENQ) begin
            if (held < lim) begin
               held++;
               keys[held] = key;
               tags[held] = tag;
               pos = held;
               while (pos > 1 && keys[pos] < keys[pos/2]) begin
                  swap_slots(pos, pos/2);
                  pos = pos/2;
               end
            end else begin
               w.status = ST_FULL;
            end
         end else if (held == 0) begin
            w.status = ST_EMPTY;
         end else begin
            w.out_key = keys[1];
            w.out_tag = tags[1];
            keys[1] = keys[held];
            tags[1] = tags[held];
            held--;
            pos = 1;
            forever begin
               c = 2*pos;
               if (c+1 <= held && keys[c+1] < keys[c]) c = c+1;
               if (c <= held && keys[c] < keys[pos]) begin
                  swap_slots(pos, c);
                  pos = c;
               end else begin
                  break;
               end
            end
         end
         w.entry_count = held[4:0];
         if (held != 0) begin
            w.head_key = keys[1];
            w.head_tag = tags[1];
         end
         pending.push_back(w);
      endfunction

      function void check_response(rsp_word_type got);
         rsp_word_type e;
         if (pending.size() == 0) begin
            $error("response word with nothing expected");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, got.status); errors++;
         end
         if (got.out_key !== e.out_key) begin
            $error("out_key exp %h got %h", e.out_key, got.out_key); errors++;
         end
         if (got.out_tag !== e.out_tag) begin
            $error("out_tag exp %h got %h", e.out_tag, got.out_tag); errors++;
         end
         if (got.entry_count !== e.entry_count) begin
            $error("entry_count exp %0d got %0d", e.entry_count, got.entry_count);
            errors++;
         end
         if (got.head_key !== e.head_key) begin
            $error("head_key exp %h got %h", e.head_key, got.head_key); errors++;
         end
         if (got.head_tag !== e.head_tag) begin
            $error("head_tag exp %h got %h", e.head_tag, got.head_tag); errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [1:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic        csr_pready;

   mhpq_req_if req_bus ();
   mhpq_rsp_if rsp_bus ();

   min_heap_priority_queue dut (
      .clock(clock), .reset(reset), .req(req_bus.sink), .rsp(rsp_bus.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   heap_scoreboard sb = new();
   bit  feed_done;
   int  idle_cycles;
   int  rsp_hold;   // long receiver hold-off request, in cycles
   int  rsp_max_gap;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1;
      req_bus.req_valid = 0; req_bus.req_type = OP_ENQ;
      req_bus.entry_key = '0; req_bus.entry_tag = '0;
      rsp_bus.rsp_ready = 0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = '0; csr_pwdata = '0;
      repeat (9) @(posedge clock);
      reset <= 0;
   end

   task automatic write_limit(int value);
      @(posedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_paddr <= REG_LIMIT;
      csr_pwdata <= value; csr_penable <= 0;
      @(posedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      sb.limit = value & 5'h1f;
   endtask

   // valid drops only before a gap, so back-to-back words keep it high
   task automatic send_word(logic op, logic [31:0] key, logic [15:0] tag, int gap);
      if (gap > 0) begin
         req_bus.req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_bus.req_valid <= 1;
      req_bus.req_type  <= op;
      req_bus.entry_key <= key;
      req_bus.entry_tag <= tag;
      do @(posedge clock); while (!req_bus.req_ready);
      sb.note_request(op, key, tag);
   endtask

   task automatic drain();
      req_bus.req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_key();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hffff_ffff;
         2: return $urandom_range(0, 7);  // many ties
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_gap();
      return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
   endfunction

   task automatic random_phase(int n, int enq_bias);
      repeat (n) begin
         send_word(($urandom_range(0, 99) < enq_bias) ? OP_ENQ : OP_DEQ,
                   pick_key(), 16'($urandom), pick_gap());
      end
   endtask

   initial begin
      int limits [6] = '{1, 16, 5, 31, 0, 9};
      sb.clear();
      feed_done = 0;
      rsp_hold = 0;
      rsp_max_gap = 17;
      wait (reset === 0);
      @(posedge clock);
      // directed: empty dequeue, extremes, ties, fill past full, then four dequeues
      send_word(OP_DEQ, 32'hffff_ffff, 16'hffff, 0);
      send_word(OP_ENQ, 32'hffff_ffff, 16'hffff, 0);
      send_word(OP_ENQ, 32'h0, 16'h0, 0);
      send_word(OP_ENQ, 32'h5, 16'h1234, 1);
      send_word(OP_ENQ, 32'h5, 16'habcd, 0);
      for (int i = 0; i < 13; i++) send_word(OP_ENQ, 32'h1000 - i, 16'(i), 0);
      for (int i = 0; i < 4; i++) send_word(OP_DEQ, $urandom, 16'($urandom), 0);
      drain();
      // limit lowered below the held count
      write_limit(2);
      send_word(OP_ENQ, 32'h7, 16'h7, 0);
      send_word(OP_DEQ, 32'h0, 16'h0, 0);
      drain();
      // back pressure: receiver stalls while requests keep coming
      write_limit(16);
      fork
         begin rsp_hold = 300; end
         random_phase(40, 70);
      join
      drain();
      foreach (limits[i]) begin
         write_limit(limits[i]);
         random_phase(120, 55);
         random_phase(80, 35);
         drain();
      end
      write_limit(16);
      random_phase(400, 52);
      drain();
      feed_done = 1;
   end

   // receiver side with random stalls and one long hold-off
   initial begin
      int gap;
      wait (reset === 0);
      forever begin
         if (rsp_hold > 0) begin
            rsp_bus.rsp_ready <= 0;
            repeat (rsp_hold) @(posedge clock);
            rsp_hold = 0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, rsp_max_gap);
         if (gap > 0) begin
            rsp_bus.rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.rsp_ready <= 1;
         do @(posedge clock); while (!rsp_bus.rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.rsp_valid && rsp_bus.rsp_ready)
         sb.check_response('{rsp_bus.status, rsp_bus.out_key, rsp_bus.out_tag,
                             rsp_bus.entry_count, rsp_bus.head_key, rsp_bus.head_tag});
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if (reset || (req_bus.req_valid && req_bus.req_ready) ||
          (rsp_bus.rsp_valid && rsp_bus.rsp_ready) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      idle_cycles = 0;
      wait (feed_done || idle_cycles >= 5000);
      if (feed_done && sb.errors == 0 && sb.pending.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
